### sv/evs_pkg.sv
`timescale 1ns / 1ps

package evs_pkg;

    // Block geometry
    localparam int MAX_BLOCK = 512;
    localparam int BLK_W     = $clog2(MAX_BLOCK + 1);

    // Field and state widths
    localparam int CMD_W      = 2;
    localparam int SAMPLE_W   = 16;
    localparam int EVENT_W    = 3;
    localparam int KEEP_W     = 10;
    localparam int CAP_W      = 24;
    localparam int THR_CFG_W  = 16;
    localparam int SIL_CFG_W  = 16;
    localparam int IDLE_CFG_W = 20;
    localparam int SQ_W       = 2 * SAMPLE_W - 1;
    localparam int ENERGY_W   = 40;
    localparam int THR_SQ_W   = 2 * (THR_CFG_W + 1) - 1;
    localparam int THR_W      = THR_SQ_W + BLK_W;
    localparam int CMP_W      = (THR_W > ENERGY_W) ? THR_W : ENERGY_W;
    localparam int SILENCE_W  = 17;
    localparam int SINCE_W    = 21;

    // APB register file
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_SILENCE   = 2'd1;
    localparam logic [1:0] REG_IDLE      = 2'd2;
    localparam logic [1:0] REG_CAPACITY  = 2'd3;

    localparam logic [THR_CFG_W-1:0]  THRESHOLD_RST = THR_CFG_W'(500);
    localparam logic [SIL_CFG_W-1:0]  SILENCE_RST   = SIL_CFG_W'(1500);
    localparam logic [IDLE_CFG_W-1:0] IDLE_RST      = IDLE_CFG_W'(10000);
    localparam logic [CAP_W-1:0]      CAPACITY_RST  = CAP_W'(160000);
    localparam logic [THR_SQ_W-1:0]   THR_SQ_RST    = THR_SQ_W'(501 * 501);

    // Commands
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

    // Events
    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_START   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_DONE    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_FULL    = 3'd3;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]           command;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       block_last;
    } in_item_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [KEEP_W-1:0]  keep_count;
        logic               recording;
        logic [CAP_W-1:0]   captured;
        logic               finished;
    } out_item_t;

    typedef struct packed {
        logic [THR_SQ_W-1:0]   thr_sq;
        logic [SIL_CFG_W-1:0]  silence_limit;
        logic [IDLE_CFG_W-1:0] idle_limit;
        logic [CAP_W-1:0]      capacity;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SQ_W-1:0]  sq;
        logic             block_last;
    } sq_item_t;

endpackage

### sv/evs_regs.sv
`timescale 1ns / 1ps

module evs_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [evs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [evs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [evs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output evs_pkg::cfg_t                    cfg
);
    import evs_pkg::*;

    logic [THR_CFG_W-1:0]  threshold_reg;
    logic [SIL_CFG_W-1:0]  silence_reg;
    logic [IDLE_CFG_W-1:0] idle_reg;
    logic [CAP_W-1:0]      capacity_reg;
    logic [THR_SQ_W-1:0]   thr_sq_reg;
    logic [THR_CFG_W:0]    thr_plus1;
    logic                  wr_en;
    logic [1:0]            reg_sel;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_sel   = paddr[3:2];
    assign thr_plus1 = {1'b0, threshold_reg} + (THR_CFG_W + 1)'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
            silence_reg   <= SILENCE_RST;
            idle_reg      <= IDLE_RST;
            capacity_reg  <= CAPACITY_RST;
            thr_sq_reg    <= THR_SQ_RST;
        end else begin
            // square of (threshold + 1) is registered in the cycle after a threshold write
            thr_sq_reg <= THR_SQ_W'(thr_plus1) * THR_SQ_W'(thr_plus1);
            if (wr_en) begin
                case (reg_sel)
                    REG_THRESHOLD: threshold_reg <= pwdata[THR_CFG_W-1:0];
                    REG_SILENCE:   silence_reg   <= pwdata[SIL_CFG_W-1:0];
                    REG_IDLE:      idle_reg      <= pwdata[IDLE_CFG_W-1:0];
                    REG_CAPACITY:  capacity_reg  <= pwdata[CAP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (reg_sel)
            REG_THRESHOLD: prdata = APB_DATA_W'(threshold_reg);
            REG_SILENCE:   prdata = APB_DATA_W'(silence_reg);
            REG_IDLE:      prdata = APB_DATA_W'(idle_reg);
            REG_CAPACITY:  prdata = APB_DATA_W'(capacity_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.thr_sq        = thr_sq_reg;
    assign cfg.silence_limit = silence_reg;
    assign cfg.idle_limit    = idle_reg;
    assign cfg.capacity      = capacity_reg;

endmodule

### sv/evs_square.sv
`timescale 1ns / 1ps

module evs_square (
    input  logic                aclk,
    input  logic                load,
    input  evs_pkg::in_item_t   item,
    output evs_pkg::sq_item_t   sq_item
);
    import evs_pkg::*;

    logic [CMD_W-1:0]              command_reg;
    logic [SQ_W-1:0]               sq_reg;
    logic                          last_reg;
    logic signed [2*SAMPLE_W-1:0]  product;

    assign product = item.sample * item.sample;

    always_ff @(posedge aclk) begin
        if (load) begin
            command_reg <= item.command;
            sq_reg      <= product[SQ_W-1:0];
            last_reg    <= item.block_last;
        end
    end

    assign sq_item.command    = command_reg;
    assign sq_item.sq         = sq_reg;
    assign sq_item.block_last = last_reg;

endmodule

### sv/evs_core.sv
`timescale 1ns / 1ps

module evs_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  evs_pkg::sq_item_t   sq_item,
    input  evs_pkg::cfg_t       cfg,
    output evs_pkg::out_item_t  result
);
    import evs_pkg::*;

    logic [ENERGY_W-1:0]  energy_reg, energy_next;
    logic [BLK_W-1:0]     count_reg, count_next;
    logic                 rec_reg, rec_next;
    logic                 armed_reg, armed_next;
    logic [SILENCE_W-1:0] elapsed_reg, elapsed_next;
    logic [SINCE_W-1:0]   since_reg, since_next;
    logic [CAP_W-1:0]     capture_reg, capture_next;
    logic                 fin_reg, fin_next;

    logic [ENERGY_W:0]    energy_sum;
    logic [ENERGY_W-1:0]  energy_add;
    logic [THR_W-1:0]     thr_prod;
    logic [BLK_W-1:0]     count_inc;
    logic                 block_close;
    logic                 voice;
    logic                 new_rec;
    logic [CAP_W-1:0]     base;
    logic [CAP_W-1:0]     space;
    logic [CAP_W-1:0]     n_ext;
    logic [CAP_W-1:0]     keep;
    logic [CAP_W-1:0]     cap_sum;
    logic [EVENT_W-1:0]   event_code;
    logic [CAP_W-1:0]     keep_out;

    // block arithmetic: compare energy with n*(threshold+1)^2 at the current threshold
    assign energy_sum  = {1'b0, energy_reg} + (ENERGY_W + 1)'(sq_item.sq);
    assign energy_add  = energy_sum[ENERGY_W] ? {ENERGY_W{1'b1}} : energy_sum[ENERGY_W-1:0];
    assign count_inc   = count_reg + BLK_W'(1);
    assign thr_prod    = THR_W'(cfg.thr_sq) * THR_W'(count_inc);
    assign block_close = sq_item.block_last || (32'(count_inc) >= 32'(MAX_BLOCK));
    assign voice       = CMP_W'(energy_add) >= CMP_W'(thr_prod);

    // capture store bookkeeping
    assign new_rec = voice && !rec_reg;
    assign base    = new_rec ? '0 : capture_reg;
    assign space   = (base < cfg.capacity) ? cfg.capacity - base : '0;
    assign n_ext   = CAP_W'(count_inc);
    assign keep    = (n_ext < space) ? n_ext : space;
    assign cap_sum = base + keep;

    always_comb begin
        energy_next  = energy_reg;
        count_next   = count_reg;
        rec_next     = rec_reg;
        armed_next   = armed_reg;
        elapsed_next = elapsed_reg;
        since_next   = since_reg;
        capture_next = capture_reg;
        fin_next     = fin_reg;
        event_code   = EV_NONE;
        keep_out     = '0;

        case (sq_item.command)
            CMD_START: begin
                energy_next  = '0;
                count_next   = '0;
                rec_next     = 1'b0;
                armed_next   = 1'b0;
                elapsed_next = '0;
                since_next   = '0;
                capture_next = '0;
                fin_next     = 1'b0;
            end
            CMD_TICK: begin
                if (!fin_reg) begin
                    if (since_reg != {SINCE_W{1'b1}}) begin
                        since_next = since_reg + SINCE_W'(1);
                    end
                    if (armed_reg && elapsed_reg != {SILENCE_W{1'b1}}) begin
                        elapsed_next = elapsed_reg + SILENCE_W'(1);
                    end
                end
            end
            CMD_SAMPLE: begin
                if (!fin_reg) begin
                    if (block_close) begin
                        energy_next  = '0;
                        count_next   = '0;
                        if (voice) begin
                            since_next   = '0;
                            armed_next   = 1'b0;
                            elapsed_next = '0;
                            rec_next     = 1'b1;
                            if (new_rec) begin
                                event_code = EV_START;
                            end
                            capture_next = cap_sum;
                            keep_out     = keep;
                            if (cap_sum >= cfg.capacity) begin
                                event_code = EV_FULL;
                                rec_next   = 1'b0;
                                fin_next   = 1'b1;
                            end
                        end else if (rec_reg) begin
                            // silent block inside a recording: store, no full check
                            capture_next = cap_sum;
                            keep_out     = keep;
                            if (!armed_reg) begin
                                armed_next   = 1'b1;
                                elapsed_next = '0;
                            end else if (elapsed_reg > SILENCE_W'(cfg.silence_limit)) begin
                                event_code = EV_DONE;
                                rec_next   = 1'b0;
                                fin_next   = 1'b1;
                            end
                        end else if (since_reg > SINCE_W'(cfg.idle_limit)) begin
                            event_code = EV_TIMEOUT;
                            fin_next   = 1'b1;
                        end
                    end else begin
                        energy_next  = energy_add;
                        count_next   = count_inc;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg  <= '0;
            count_reg   <= '0;
            rec_reg     <= 1'b0;
            armed_reg   <= 1'b0;
            elapsed_reg <= '0;
            since_reg   <= '0;
            capture_reg <= '0;
            fin_reg     <= 1'b1;
        end else if (advance) begin
            energy_reg  <= energy_next;
            count_reg   <= count_next;
            rec_reg     <= rec_next;
            armed_reg   <= armed_next;
            elapsed_reg <= elapsed_next;
            since_reg   <= since_next;
            capture_reg <= capture_next;
            fin_reg     <= fin_next;
        end
    end

    assign result.event_res  = event_code;
    assign result.keep_count = KEEP_W'(keep_out);
    assign result.recording  = rec_next;
    assign result.captured   = capture_next;
    assign result.finished   = fin_next;

endmodule

### sv/energy_vad_segmenter.sv
`timescale 1ns / 1ps

// Energy voice activity detector with silence hangover. One transaction is
// taken per clock while s_ready is high: a sample, a millisecond tick or a
// start command, and each gives exactly one result (the sample square is
// registered first, then the detector state is updated and the result
// register loaded). Throughput is one transaction per cycle for as long as the
// result side keeps up; the state update of the second stage carries the
// item-to-item dependency. A block is judged voice when its energy reaches
// n*(threshold+1)^2, formed at block close by one narrow multiply of the
// sample count with the squared threshold, so no divider or root is used.
// The squared threshold is recomputed in the cycle after a threshold write.
// Registers sit at byte addresses 0x0 threshold, 0x4 silence limit,
// 0x8 idle limit, 0xC capacity.
module energy_vad_segmenter (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  evs_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output evs_pkg::out_item_t               m_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [evs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [evs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [evs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import evs_pkg::*;

    cfg_t      cfg;
    sq_item_t  sq_item;
    out_item_t result;
    out_item_t out_reg;
    logic      sq_valid_reg;
    logic      out_valid_reg;
    logic      out_load;
    logic      sq_load;

    // advance the result stage when it is empty or being drained
    assign out_load = sq_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !sq_valid_reg || out_load;
    assign sq_load  = s_valid && s_ready;

    evs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    evs_square u_square (
        .aclk    (aclk),
        .load    (sq_load),
        .item    (s_data),
        .sq_item (sq_item)
    );

    evs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (out_load),
        .sq_item (sq_item),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                sq_valid_reg <= s_valid;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_rec_not_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.recording && m_data.finished))
        else $error("recording and finished both set");

    a_full_finishes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.event_res == EV_FULL) |-> (m_data.finished && !m_data.recording))
        else $error("full event without finishing");

    a_start_records: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.event_res == EV_START) |-> m_data.recording)
        else $error("voice start without recording");

    a_stage_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (sq_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("result stage failed to load");

endmodule

### tb/energy_vad_segmenter_test.sv
`timescale 1ns / 1ps

module energy_vad_segmenter_test;
    import evs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int AMP_QUIET = 0;
    localparam int AMP_LOUD  = 1;
    localparam int AMP_WILD  = 2;

    localparam int PHASE_ITEMS = 85;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    energy_vad_segmenter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 aclk = ~aclk;

    // Register copies
    logic [THR_CFG_W-1:0]  cfg_thr  = THRESHOLD_RST;
    logic [SIL_CFG_W-1:0]  cfg_sil  = SILENCE_RST;
    logic [IDLE_CFG_W-1:0] cfg_idle = IDLE_RST;
    logic [CAP_W-1:0]      cfg_cap  = CAPACITY_RST;

    // Detector state
    logic [ENERGY_W-1:0]  energy_acc     = '0;
    logic [KEEP_W-1:0]    blk_len        = '0;
    bit                   rec_on         = 1'b0;
    bit                   hang_armed     = 1'b0;
    logic [SILENCE_W-1:0] hang_ms        = '0;
    logic [SINCE_W-1:0]   quiet_ms       = '0;
    logic [CAP_W-1:0]     kept_total     = '0;
    bit                   awaiting_start = 1'b1;

    in_item_t    items_to_send[$];
    out_item_t   vad_reports_due[$];
    int unsigned queued_items = 0;
    int unsigned errors = 0;

    bit          item_held  = 1'b0;
    int unsigned send_wait  = 0;
    bit          send_burst = 1'b0;
    int unsigned recv_wait  = 0;
    bit          recv_burst = 1'b0;

    function automatic int unsigned draw_wait(inout bit quiet);
        if ($urandom_range(0, 39) == 0) quiet = !quiet;
        if (quiet) return 0;
        if ($urandom_range(0, 2) == 0) return $urandom_range(0, 19);
        return $urandom_range(0, 3);
    endfunction

    function automatic int unsigned store_samples(input int unsigned n);
        int unsigned room;
        int unsigned take;
        room = (kept_total < cfg_cap) ? 32'(cfg_cap - kept_total) : 0;
        take = (n < room) ? n : room;
        kept_total += CAP_W'(take);
        return take;
    endfunction

    function automatic out_item_t predict_vad_report(input in_item_t it);
        out_item_t       rep;
        longint signed   smp;
        longint unsigned nrg;
        longint unsigned t1;
        longint unsigned n;
        int unsigned     keep;
        bit              voiced;
        rep = '0;
        rep.event_res = EV_NONE;
        keep = 0;
        if (it.command == CMD_START) begin
            energy_acc     = '0;
            blk_len        = '0;
            rec_on         = 1'b0;
            hang_armed     = 1'b0;
            hang_ms        = '0;
            quiet_ms       = '0;
            kept_total     = '0;
            awaiting_start = 1'b0;
        end else if (it.command == CMD_TICK && !awaiting_start) begin
            if (quiet_ms != '1) quiet_ms++;
            if (hang_armed && hang_ms != '1) hang_ms++;
        end else if (it.command == CMD_SAMPLE && !awaiting_start) begin
            smp = $signed(it.sample);
            nrg = 64'(energy_acc);
            nrg += smp * smp;
            if (nrg > 64'hFF_FFFF_FFFF) nrg = 64'hFF_FFFF_FFFF;
            energy_acc = nrg[ENERGY_W-1:0];
            blk_len++;
            if (it.block_last || blk_len >= MAX_BLOCK) begin
                n = 64'(blk_len);
                t1 = 64'(cfg_thr);
                t1 += 1;
                voiced = 64'(energy_acc) >= t1 * t1 * n;
                if (voiced) begin
                    quiet_ms = '0;
                    if (!rec_on) begin
                        rec_on = 1'b1;
                        kept_total = '0;
                        rep.event_res = EV_START;
                    end
                    hang_armed = 1'b0;
                    hang_ms = '0;
                    keep = store_samples(32'(n));
                    if (kept_total >= cfg_cap) begin
                        rep.event_res = EV_FULL;
                        rec_on = 1'b0;
                        awaiting_start = 1'b1;
                    end
                end else if (rec_on) begin
                    // silent block still goes to the store, full or not
                    keep = store_samples(32'(n));
                    if (!hang_armed) begin
                        hang_armed = 1'b1;
                        hang_ms = '0;
                    end else if (hang_ms > cfg_sil) begin
                        rep.event_res = EV_DONE;
                        rec_on = 1'b0;
                        awaiting_start = 1'b1;
                    end
                end else if (quiet_ms > cfg_idle) begin
                    rep.event_res = EV_TIMEOUT;
                    awaiting_start = 1'b1;
                end
                energy_acc = '0;
                blk_len = '0;
            end
        end
        rep.keep_count = KEEP_W'(keep);
        rep.recording  = rec_on;
        rep.captured   = kept_total;
        rep.finished   = awaiting_start;
        return rep;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want, got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
            errors++;
        end
    endtask

    task automatic check_report(input out_item_t got);
        out_item_t want;
        if (vad_reports_due.size() == 0) begin
            $display("%0t: result with no transaction pending, expected none, got %h",
                     $time, got);
            errors++;
        end else begin
            want = vad_reports_due.pop_front();
            check_field("event_res", 32'(want.event_res), 32'(got.event_res));
            check_field("keep_count", 32'(want.keep_count), 32'(got.keep_count));
            check_field("recording", 32'(want.recording), 32'(got.recording));
            check_field("captured", 32'(want.captured), 32'(got.captured));
            check_field("finished", 32'(want.finished), 32'(got.finished));
        end
    endtask

    // Input side: hold each transaction until accepted, then wait the drawn gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            item_held = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                vad_reports_due.push_back(predict_vad_report(s_data));
                item_held = 1'b0;
            end
            if (!item_held) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (items_to_send.size() != 0) begin
                    s_data <= items_to_send.pop_front();
                    s_valid <= 1'b1;
                    item_held = 1'b1;
                    send_wait = draw_wait(send_burst);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: check each transaction, then stall for the drawn count
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_report(m_data);
                recv_wait = draw_wait(recv_burst);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] smp,
                             input bit last);
        in_item_t it;
        it.command    = cmd;
        it.sample     = smp;
        it.block_last = last;
        items_to_send.push_back(it);
        queued_items++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int kind);
        int mag;
        int top;
        top = (cfg_thr < 16'd32767) ? int'(cfg_thr) : 32767;
        case (kind)
            AMP_LOUD: begin
                if (cfg_thr >= 16'd32767) begin
                    mag = 32767;
                end else begin
                    // often sit right on the voice boundary
                    mag = int'(cfg_thr) + 1;
                    if ($urandom_range(0, 3) != 0) mag += $urandom_range(0, cfg_thr / 2 + 2);
                    if (mag > 32767) mag = 32767;
                end
            end
            AMP_QUIET: begin
                mag = ($urandom_range(0, 3) == 0) ? top : $urandom_range(0, top);
            end
            default: return SAMPLE_W'($urandom);
        endcase
        return $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
    endfunction

    task automatic push_block(input int len, input int kind);
        for (int i = 0; i < len; i++) push_item(CMD_SAMPLE, pick_sample(kind), i == len - 1);
    endtask

    task automatic push_episode();
        int nblk;
        int len;
        push_item(CMD_START, SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
        nblk = $urandom_range(1, 10);
        repeat (nblk) begin
            repeat ($urandom_range(0, 4))
                push_item(CMD_TICK, SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
            len = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_block(len, AMP_LOUD);
                4, 5, 6, 7: push_block(len, AMP_QUIET);
                8: push_block(len, AMP_WILD);
                default: push_item(CMD_W'($urandom_range(0, 2)), SAMPLE_W'($urandom),
                                   1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [THR_CFG_W-1:0] thr, input logic [SIL_CFG_W-1:0] sil,
                              input logic [IDLE_CFG_W-1:0] idle, input logic [CAP_W-1:0] cap);
        apb_write(REG_THRESHOLD, APB_DATA_W'(thr));
        apb_write(REG_SILENCE, APB_DATA_W'(sil));
        apb_write(REG_IDLE, APB_DATA_W'(idle));
        apb_write(REG_CAPACITY, APB_DATA_W'(cap));
        cfg_thr  = thr;
        cfg_sil  = sil;
        cfg_idle = idle;
        cfg_cap  = cap;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (items_to_send.size() != 0 || item_held || vad_reports_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int unsigned phase_start;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: ignored traffic before start, then a short recording
        push_item(CMD_SAMPLE, 16'h7FFF, 1'b1);
        push_item(CMD_TICK, 16'h0000, 1'b0);
        push_item(CMD_UNUSED, 16'h8000, 1'b1);
        push_item(CMD_START, 16'h0000, 1'b0);
        push_item(CMD_SAMPLE, 16'h8000, 1'b1);
        push_item(CMD_SAMPLE, 16'h7FFF, 1'b1);
        push_item(CMD_SAMPLE, 16'h0000, 1'b1);
        push_item(CMD_START, 16'h0000, 1'b0);
        wait_drained();

        set_config(16'd100, 16'd1, 20'd2, 24'd5);
        // idle timeout
        repeat (3) push_item(CMD_TICK, 16'h0000, 1'b0);
        push_item(CMD_SAMPLE, 16'd100, 1'b1);
        push_item(CMD_TICK, 16'h0000, 1'b0);
        // exact boundary is voice, then hangover runs out
        push_item(CMD_START, 16'h0000, 1'b0);
        push_item(CMD_SAMPLE, 16'd101, 1'b1);
        push_item(CMD_SAMPLE, SAMPLE_W'(-101), 1'b0);
        push_item(CMD_SAMPLE, 16'h0000, 1'b1);
        repeat (2) push_item(CMD_TICK, 16'h0000, 1'b0);
        push_item(CMD_SAMPLE, 16'h0000, 1'b1);
        // fill the store on a voice block
        push_item(CMD_START, 16'h0000, 1'b0);
        push_item(CMD_SAMPLE, 16'h7FFF, 1'b0);
        push_item(CMD_SAMPLE, 16'h8000, 1'b1);
        push_item(CMD_SAMPLE, 16'd20000, 1'b0);
        push_item(CMD_SAMPLE, SAMPLE_W'(-20000), 1'b0);
        push_item(CMD_SAMPLE, 16'd20000, 1'b1);
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: set_config('0, '0, '0, 24'd1);
                1: set_config('1, '1, '1, '1);
                2: set_config(THR_CFG_W'($urandom_range(0, 3000)),
                              SIL_CFG_W'($urandom_range(0, 6)),
                              IDLE_CFG_W'($urandom_range(0, 40)),
                              CAP_W'($urandom_range(600, 5000)));
                default: set_config(THR_CFG_W'($urandom_range(0, 20000)),
                                    SIL_CFG_W'($urandom_range(0, 10)),
                                    IDLE_CFG_W'($urandom_range(0, 40)),
                                    CAP_W'($urandom_range(1, 400)));
            endcase
            if (p == 2) begin
                // overlong block closes by itself at the maximum length
                push_item(CMD_START, 16'h0000, 1'b0);
                push_block(MAX_BLOCK + 18, AMP_LOUD);
            end
            phase_start = queued_items;
            while (queued_items - phase_start < PHASE_ITEMS) push_episode();
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("energy_vad_segmenter_test: done, clean");
        end else begin
            $display("energy_vad_segmenter_test: done, errors");
        end
        $finish;
    end

    initial begin
        #1_500_000;
        $display("energy_vad_segmenter_test: done, errors");
        $finish;
    end

endmodule

### sim.f
sv/evs_pkg.sv
sv/evs_regs.sv
sv/evs_square.sv
sv/evs_core.sv
sv/energy_vad_segmenter.sv
tb/energy_vad_segmenter_test.sv
